// ===== sv/gdps_pkg.sv =====
package gdps_pkg;

	localparam int unsigned MAX_VERTICES_DEF = 32;
	localparam int unsigned VTX_W = 5;
	localparam int unsigned CNT_W = 6;
	localparam int unsigned STATUS_W = 3;
	localparam logic [CNT_W-1:0] VCOUNT_RESET = 6'd32;

	localparam logic [STATUS_W-1:0] ST_ADDED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DUP = 3'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 3'd2;
	localparam logic [STATUS_W-1:0] ST_PATH = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOPATH = 3'd4;

	localparam logic REQ_ADD = 1'b0;
	localparam logic REQ_FIND = 1'b1;

	typedef struct packed {
		logic req_type;
		logic [VTX_W-1:0] source_vertex;
		logic [VTX_W-1:0] target_vertex;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [VTX_W-1:0] path_vertex;
		logic last;
	} rsp_t;

endpackage

// ===== sv/graph_dfs_path_search_top.sv =====
// Add-edge: one adjacency read per cycle, plus result handoff.
// Find-path: each stack step runs one or two adjacency scans, each reading the neighbor memory
// through its single read port; path results go out in stack order, held while the output is busy.
// One transaction is processed at a time; the next is taken once its results are queued.
// Reset (arst_n, asynchronous, active low) clears degrees, search state, the output register
// and sets vertex_count to 32; the neighbor memory is not cleared.
module graph_dfs_path_search_top import gdps_pkg::*; #(
	parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  req_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output rsp_t out_data,
	input  logic cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata
);

	localparam int unsigned AW = $clog2(MAX_VERTICES * MAX_VERTICES);

	logic mem_we;
	logic [AW-1:0] mem_waddr;
	logic [AW-1:0] mem_raddr;
	logic [VTX_W-1:0] mem_wdata;
	logic [VTX_W-1:0] mem_rdata;

	gdps_ctrl #(.N(MAX_VERTICES)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	gdps_nbr_mem #(.N(MAX_VERTICES)) u_nbr_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule

// ===== sv/gdps_nbr_mem.sv =====
module gdps_nbr_mem import gdps_pkg::*; #(
	parameter int unsigned N = MAX_VERTICES_DEF
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(N*N)-1:0] waddr,
	input  logic [VTX_W-1:0] wdata,
	input  logic [$clog2(N*N)-1:0] raddr,
	output logic [VTX_W-1:0] rdata
);

	logic [VTX_W-1:0] mem [N*N];
	logic [VTX_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/gdps_ctrl.sv =====
module gdps_ctrl import gdps_pkg::*; #(
	parameter int unsigned N = MAX_VERTICES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  req_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output rsp_t out_data,
	input  logic cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	output logic mem_we,
	output logic [$clog2(N*N)-1:0] mem_waddr,
	output logic [VTX_W-1:0] mem_wdata,
	output logic [$clog2(N*N)-1:0] mem_raddr,
	input  logic [VTX_W-1:0] mem_rdata
);

	localparam int unsigned VW = $clog2(N);
	localparam int unsigned DW = $clog2(N + 1);
	localparam int unsigned AW = $clog2(N * N);

	typedef enum logic [2:0] {S_IDLE, S_RESP, S_TOP, S_SCAN, S_EMIT} state_t;

	state_t state_q;
	logic req_type_q;
	logic [VTX_W-1:0] dst_q;
	logic [CNT_W-1:0] vcount_q;
	logic [DW-1:0] deg_q [N];
	logic [N-1:0] visited_q;
	logic [VW-1:0] stack_q [N];
	logic [DW-1:0] depth_q;
	logic [VW-1:0] top_q;
	logic [DW-1:0] tdeg_q;
	logic [DW-1:0] k_q;
	logic [DW-1:0] e_q;
	logic rv_s1;
	logic push_mode_q;
	logic [STATUS_W-1:0] res_q;
	logic out_valid_q;
	rsp_t out_q;

	logic [CNT_W-1:0] lim;
	logic out_of_range;
	logic out_free;
	logic issue;
	logic match;
	logic scan_done;
	logic [AW-1:0] base;
	logic [DW-1:0] depth_m1;
	logic [VW-1:0] in_src;
	logic [VW-1:0] top_v;

	assign lim = (vcount_q > CNT_W'(N)) ? CNT_W'(N) : vcount_q;
	assign out_of_range = (CNT_W'(in_data.source_vertex) >= lim)
		|| (CNT_W'(in_data.target_vertex) >= lim);
	assign out_free = !out_valid_q || out_ready;
	assign in_src = VW'(in_data.source_vertex);
	assign depth_m1 = depth_q - DW'(1);
	assign top_v = stack_q[depth_m1[VW-1:0]];

	assign base = AW'(top_q) * AW'(N);
	assign issue = k_q < tdeg_q;
	// The check sees the read data in the cycle after its read address, since the memory output is registered.
	assign match = rv_s1 && (push_mode_q ? !visited_q[VW'(mem_rdata)] : (mem_rdata == dst_q));
	assign scan_done = !rv_s1 && !issue;

	assign mem_raddr = base + AW'(k_q);
	assign mem_waddr = base + AW'(tdeg_q);
	assign mem_wdata = dst_q;
	assign mem_we = (state_q == S_SCAN) && (req_type_q == REQ_ADD) && !match && scan_done
		&& (tdeg_q < DW'(N));

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			req_type_q <= REQ_ADD;
			dst_q <= '0;
			vcount_q <= VCOUNT_RESET;
			for (int i = 0; i < N; i++) begin
				deg_q[i] <= '0;
				stack_q[i] <= '0;
			end
			visited_q <= '0;
			depth_q <= '0;
			top_q <= '0;
			tdeg_q <= '0;
			k_q <= '0;
			e_q <= '0;
			rv_s1 <= 1'b0;
			push_mode_q <= 1'b0;
			res_q <= ST_ADDED;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (cfg_we) begin
				vcount_q <= cfg_wdata;
			end
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (out_of_range) begin
							res_q <= ST_RANGE;
							state_q <= S_RESP;
						end else begin
							req_type_q <= in_data.req_type;
							dst_q <= in_data.target_vertex;
							top_q <= in_src;
							tdeg_q <= deg_q[in_src];
							k_q <= '0;
							rv_s1 <= 1'b0;
							push_mode_q <= 1'b0;
							if (in_data.req_type == REQ_ADD) begin
								state_q <= S_SCAN;
							end else begin
								visited_q <= '0;
								stack_q[0] <= in_src;
								depth_q <= DW'(1);
								state_q <= S_TOP;
							end
						end
					end
				end
				S_RESP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_q <= '{status: res_q, path_vertex: '0, last: 1'b1};
						state_q <= S_IDLE;
					end
				end
				S_TOP: begin
					if (depth_q == '0) begin
						res_q <= ST_NOPATH;
						state_q <= S_RESP;
					end else begin
						top_q <= top_v;
						tdeg_q <= deg_q[top_v];
						k_q <= '0;
						rv_s1 <= 1'b0;
						push_mode_q <= visited_q[top_v];
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					rv_s1 <= issue;
					if (issue) begin
						k_q <= k_q + DW'(1);
					end
					if (match) begin
						rv_s1 <= 1'b0;
						if (req_type_q == REQ_ADD) begin
							res_q <= ST_DUP;
							state_q <= S_RESP;
						end else if (!push_mode_q) begin
							e_q <= '0;
							state_q <= S_EMIT;
						end else begin
							if (depth_q < DW'(N)) begin
								stack_q[depth_q[VW-1:0]] <= VW'(mem_rdata);
								depth_q <= depth_q + DW'(1);
							end else begin
								depth_q <= depth_m1;
							end
							state_q <= S_TOP;
						end
					end else if (scan_done) begin
						if (req_type_q == REQ_ADD) begin
							if (tdeg_q < DW'(N)) begin
								deg_q[top_q] <= tdeg_q + DW'(1);
								res_q <= ST_ADDED;
							end else begin
								res_q <= ST_DUP;
							end
							state_q <= S_RESP;
						end else if (!push_mode_q) begin
							// First visit without the goal nearby: mark it and look for a child.
							visited_q[top_q] <= 1'b1;
							push_mode_q <= 1'b1;
							k_q <= '0;
						end else begin
							depth_q <= depth_m1;
							state_q <= S_TOP;
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (e_q < depth_q) begin
							out_q <= '{status: ST_PATH,
								path_vertex: VTX_W'(stack_q[e_q[VW-1:0]]), last: 1'b0};
							e_q <= e_q + DW'(1);
						end else begin
							out_q <= '{status: ST_PATH, path_vertex: dst_q, last: 1'b1};
							depth_q <= '0;
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(N)) else $error("stack depth exceeds vertex limit");

	a_tdeg_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tdeg_q <= DW'(N)) else $error("adjacency length exceeds vertex limit");

	a_zero_vertex: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status != ST_PATH) |-> (out_q.path_vertex == '0))
		else $error("non-path result carries a vertex");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second transaction taken while busy");

endmodule
